/* rtl/rxlb_pkg.sv */
// Shared types and constants for the receive ring buffer with line mark.
// No dependencies; every other file of the block imports this package.
package rxlb_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;
    localparam int POS_W       = 9;
    localparam int LEVEL_W     = 9;
    localparam int CMD_W       = 3;
    localparam int S_TDATA_W   = 16;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 1;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int QDEPTH      = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 9'd200;
    localparam logic [BYTE_W-1:0]  SEP_RESET   = 8'h0A;

    localparam logic [CFG_INDEX_W-1:0] CFG_ALMOST_FULL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATOR   = 1'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH       = 3'd0,
        CMD_READ_COUNT = 3'd1,
        CMD_READ_LINE  = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t          code;
        logic [BYTE_W-1:0]  data_byte;
        logic [LEN_W-1:0]   want;
    } cmd_item_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_EMIT  = 3'b100
    } back_state_t;

endpackage

/* rtl/uart_rx_line_ring_buffer_unit.sv */
// Push and clear update the registered pointers when the back end takes them; a read runs
// fetch then emit for each byte, set by the registered read of the single ring memory, and
// a stalled output holds emit. Pushes sustain one item per cycle while the back end is free.
// Reset clears pointers, line mark and the queue and loads the level 200 and separator 0x0A;
// ring contents stay undefined, with no clear pass.
// Top level: joins rxlb_front and rxlb_back; depends on rxlb_pkg.
module uart_rx_line_ring_buffer_unit #(
    parameter int RING_DEPTH = 512,
    parameter int RUN_LIMIT  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_byte [7:0], read_length [14:8], zero [15].
    input  logic [rxlb_pkg::S_TDATA_W-1:0]   s_tdata,
    // command [2:0].
    input  logic [rxlb_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte [7:0], read_pos [16:8], write_pos [25:17], mark_pos [34:26], zero [39:35].
    output logic [rxlb_pkg::M_TDATA_W-1:0]   m_tdata,
    // empty_res [0].
    output logic [rxlb_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rxlb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rxlb_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import rxlb_pkg::*;

    logic      q_valid;
    logic      q_ready;
    cmd_item_t q_item;

    assign cfg_ready = 1'b1;

    rxlb_front #(
        .RUN_LIMIT (RUN_LIMIT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    rxlb_back #(
        .RING_DEPTH (RING_DEPTH),
        .RUN_LIMIT  (RUN_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

/* rtl/rxlb_front.sv */
// Front end: accepts input items, decodes the command, clamps the read length
// and holds decoded commands in a two-entry queue. Depends on rxlb_pkg.
module rxlb_front #(
    parameter int RUN_LIMIT = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rxlb_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [rxlb_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          q_valid,
    input  logic                          q_ready,
    output rxlb_pkg::cmd_item_t           q_item
);
    import rxlb_pkg::*;

    localparam int QPW = $clog2(QDEPTH);

    cmd_item_t          q_mem [QDEPTH];
    logic [QPW-1:0]     wp_reg;
    logic [QPW-1:0]     rp_reg;
    logic [QPW:0]       cnt_reg;
    logic [QPW:0]       cnt_next;
    cmd_item_t          item;
    logic [LEN_W-1:0]   len;
    logic               known;
    logic               push;
    logic               pop;

    always_comb
    begin
        len            = s_tdata[BYTE_W +: LEN_W];
        known          = s_tuser[CMD_W-1:0] <= CMD_W'(CMD_QUERY);
        item.code      = cmd_code_t'(s_tuser[CMD_W-1:0]);
        item.data_byte = s_tdata[BYTE_W-1:0];
        item.want      = (len > LEN_W'(RUN_LIMIT)) ? LEN_W'(RUN_LIMIT) : len;
    end

    assign s_tready = cnt_reg != (QPW+1)'(QDEPTH);
    assign q_valid  = cnt_reg != '0;
    assign q_item   = q_mem[rp_reg];
    assign push     = s_tvalid && s_tready && known;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= item;
        end
    end

endmodule

/* rtl/rxlb_back.sv */
// Back end: ring memory, pointers, line mark and configuration registers;
// executes queued commands and drives the registered result stage. Depends on rxlb_pkg.
module rxlb_back #(
    parameter int RING_DEPTH = 512,
    parameter int RUN_LIMIT  = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  rxlb_pkg::cmd_item_t             q_item,
    input  logic                            cfg_valid,
    input  logic [rxlb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rxlb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rxlb_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [rxlb_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import rxlb_pkg::*;

    localparam int AW   = $clog2(RING_DEPTH);
    localparam int PW   = (AW > POS_W) ? AW : POS_W;
    localparam int CNTW = $clog2(RUN_LIMIT + 1);

    function automatic logic [AW-1:0] ring_dist(input logic [AW-1:0] to,
                                                input logic [AW-1:0] from);
        logic [AW:0] d;
        d = {1'b0, to} - {1'b0, from};
        if (d[AW])
        begin
            d = d + (AW+1)'(RING_DEPTH);
        end
        return d[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_W-1:0]  mem [RING_DEPTH];
    logic [BYTE_W-1:0]  rdata_reg;
    logic               mem_we;

    back_state_t        state_reg, state_next;
    logic [AW-1:0]      wr_reg, wr_next;
    logic [AW-1:0]      rd_reg, rd_next;
    logic [AW-1:0]      mark_reg, mark_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [BYTE_W-1:0]  sep_reg;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [CNTW-1:0]    limit_reg, limit_next;
    logic               line_reg, line_next;
    logic [CNTW-1:0]    cnt_plus;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_empty_reg, out_empty_next;
    logic [POS_W-1:0]   out_rp_reg, out_rp_next;
    logic [POS_W-1:0]   out_wp_reg, out_wp_next;
    logic [POS_W-1:0]   out_mp_reg, out_mp_next;
    logic               load;
    logic               out_free;
    logic               emit_last;

    logic [AW-1:0]      fill;
    logic [AW-1:0]      avail;
    logic [AW-1:0]      tail;
    logic [AW-1:0]      new_fill;
    logic               advance;
    logic [PW-1:0]      rd_wide;
    logic [PW-1:0]      wr_wide;
    logic [PW-1:0]      mark_wide;

    assign fill      = ring_dist(wr_reg, rd_reg);
    assign avail     = ring_dist(mark_reg, rd_reg);
    assign tail      = ring_dist(wr_reg, mark_reg);
    assign advance   = fill < AW'(RING_DEPTH - 1);
    assign new_fill  = advance ? fill + 1'b1 : fill;
    assign rd_wide   = PW'(rd_reg);
    assign wr_wide   = PW'(wr_reg);
    assign mark_wide = PW'(mark_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign cnt_plus  = cnt_reg + 1'b1;
    assign emit_last = (cnt_plus == limit_reg) || (line_reg && rdata_reg == sep_reg);

    always_comb
    begin
        state_next     = state_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        mark_next      = mark_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        line_next      = line_reg;
        q_ready        = 1'b0;
        mem_we         = 1'b0;
        load           = 1'b0;
        out_byte_next  = '0;
        out_last_next  = 1'b1;
        out_empty_next = 1'b1;
        out_rp_next    = '0;
        out_wp_next    = '0;
        out_mp_next    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.code)
                        CMD_PUSH:
                        begin
                            q_ready = 1'b1;
                            mem_we  = 1'b1;
                            wr_next = advance ? ring_inc(wr_reg) : wr_reg;
                            if ((PW'(new_fill) >= PW'(level_reg))
                                || (q_item.data_byte == sep_reg))
                            begin
                                mark_next = wr_next;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            q_ready   = 1'b1;
                            rd_next   = wr_reg;
                            mark_next = wr_reg;
                        end
                        CMD_QUERY:
                        begin
                            if (out_free)
                            begin
                                q_ready        = 1'b1;
                                load           = 1'b1;
                                out_empty_next = 1'b0;
                                out_rp_next    = rd_wide[POS_W-1:0];
                                out_wp_next    = wr_wide[POS_W-1:0];
                                out_mp_next    = mark_wide[POS_W-1:0];
                            end
                        end
                        CMD_READ_COUNT:
                        begin
                            if ((q_item.want == '0) || (PW'(fill) < PW'(q_item.want)))
                            begin
                                if (out_free)
                                begin
                                    q_ready = 1'b1;
                                    load    = 1'b1;
                                end
                            end
                            else
                            begin
                                q_ready    = 1'b1;
                                limit_next = CNTW'(q_item.want);
                                cnt_next   = '0;
                                line_next  = 1'b0;
                                state_next = ST_FETCH;
                            end
                        end
                        CMD_READ_LINE:
                        begin
                            if ((fill <= tail) || (avail == '0))
                            begin
                                if (out_free)
                                begin
                                    q_ready = 1'b1;
                                    load    = 1'b1;
                                end
                            end
                            else
                            begin
                                q_ready    = 1'b1;
                                limit_next = (PW'(avail) < PW'(RUN_LIMIT))
                                             ? CNTW'(avail) : CNTW'(RUN_LIMIT);
                                cnt_next   = '0;
                                line_next  = 1'b1;
                                state_next = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            q_ready = 1'b1;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    out_byte_next  = rdata_reg;
                    out_last_next  = emit_last;
                    out_empty_next = 1'b0;
                    cnt_next       = cnt_plus;
                    rd_next        = ring_inc(rd_reg);
                    state_next     = emit_last ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_reg        <= '0;
            rd_reg        <= '0;
            mark_reg      <= '0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            line_reg      <= 1'b0;
            level_reg     <= LEVEL_RESET;
            sep_reg       <= SEP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            mark_reg  <= mark_next;
            cnt_reg   <= cnt_next;
            limit_reg <= limit_next;
            line_reg  <= line_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_ALMOST_FULL: level_reg <= cfg_data[LEVEL_W-1:0];
                    CFG_SEPARATOR:   sep_reg   <= cfg_data[BYTE_W-1:0];
                    default:         level_reg <= level_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_reg] <= q_item.data_byte;
        end
        rdata_reg <= mem[rd_reg];
        if (load)
        begin
            out_byte_reg  <= out_byte_next;
            out_last_reg  <= out_last_next;
            out_empty_reg <= out_empty_next;
            out_rp_reg    <= out_rp_next;
            out_wp_reg    <= out_wp_next;
            out_mp_reg    <= out_mp_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;
    assign m_tdata  = {5'd0, out_mp_reg, out_wp_reg, out_rp_reg, out_byte_reg};

endmodule

/* rtl/rxlb_checker.sv */
// Port-level checks on the result stream of the ring buffer, bound to the top level.
// Depends on rxlb_pkg and uart_rx_line_ring_buffer_unit.
module rxlb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rxlb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [rxlb_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import rxlb_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result item changed.");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("Empty result item is not the last of its run.");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("Empty result item carries data.");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("Result item shown during reset.");

endmodule

bind uart_rx_line_ring_buffer_unit rxlb_checker u_rxlb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/uart_rx_line_ring_buffer_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for uart_rx_line_ring_buffer_unit: directed table, then random bursts
// with stalls on both streams, checked against a behavioral ring-buffer predictor.
// Depends on rxlb_pkg and the RTL of the block only.
module uart_rx_line_ring_buffer_unit_test;
    import rxlb_pkg::*;

    localparam int RING_SIZE     = 512;
    localparam int RUN_MAX       = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_ROWS      = 27;

    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              empty_res;
        logic [POS_W-1:0]  read_pos;
        logic [POS_W-1:0]  write_pos;
        logic [POS_W-1:0]  mark_pos;
    } ring_result_t;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
        int                reps;
        bit                fixed;
        ring_result_t      res;
    } stim_row_t;

    localparam ring_result_t NO_DATA = '{8'h00, 1'b1, 1'b1, 9'd0, 9'd0, 9'd0};

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [S_TUSER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [BYTE_W-1:0]  ring_mem [RING_SIZE];
    logic [POS_W-1:0]   wr_ix;
    logic [POS_W-1:0]   rd_ix;
    logic [POS_W-1:0]   mark_ix;
    logic [LEVEL_W-1:0] af_level;
    logic [BYTE_W-1:0]  sep_val;

    ring_result_t awaited_out [$];
    ring_result_t head_res;
    stim_row_t    directed_rows [NUM_ROWS];
    int           mismatch_count;
    bit           no_idle;
    bit           hold_req;

    uart_rx_line_ring_buffer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    function automatic ring_result_t pos_reply(input logic [POS_W-1:0] rp,
                                               input logic [POS_W-1:0] wp,
                                               input logic [POS_W-1:0] mp);
        ring_result_t r;
        r = '{8'h00, 1'b1, 1'b0, rp, wp, mp};
        return r;
    endfunction

    // Applies one accepted item to the predicted ring state and queues the results it causes.
    task automatic ring_apply(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                              input logic [LEN_W-1:0] len);
        logic [POS_W-1:0] fill;
        logic [POS_W-1:0] level_now;
        logic [POS_W-1:0] avail;
        logic [POS_W-1:0] past_mark;
        logic [LEN_W-1:0] count;
        logic [BYTE_W-1:0] b;
        int n;
        fill = wr_ix - rd_ix;
        case (cmd)
            CMD_PUSH:
            begin
                ring_mem[wr_ix] = data;
                if (fill < RING_SIZE - 1)
                    wr_ix = wr_ix + 1'b1;
                level_now = wr_ix - rd_ix;
                if (level_now >= af_level || data == sep_val)
                    mark_ix = wr_ix;
            end
            CMD_READ_COUNT:
            begin
                count = (len > RUN_MAX) ? LEN_W'(RUN_MAX) : len;
                if (count == 0 || fill < count)
                    awaited_out.push_back(NO_DATA);
                else
                    for (n = 0; n < count; n++)
                    begin
                        awaited_out.push_back('{ring_mem[rd_ix], n == count - 1, 1'b0,
                                                9'd0, 9'd0, 9'd0});
                        rd_ix = rd_ix + 1'b1;
                    end
            end
            CMD_READ_LINE:
            begin
                avail = mark_ix - rd_ix;
                past_mark = wr_ix - mark_ix;
                if (fill <= past_mark || avail == 0)
                    awaited_out.push_back(NO_DATA);
                else
                begin
                    n = 0;
                    while (n < avail && n < RUN_MAX)
                    begin
                        b = ring_mem[rd_ix];
                        awaited_out.push_back('{b, 1'b0, 1'b0, 9'd0, 9'd0, 9'd0});
                        n++;
                        rd_ix = rd_ix + 1'b1;
                        if (b == sep_val)
                            break;
                    end
                    awaited_out[awaited_out.size() - 1].last = 1'b1;
                end
            end
            CMD_CLEAR:
            begin
                rd_ix = wr_ix;
                mark_ix = wr_ix;
            end
            CMD_QUERY:
                awaited_out.push_back(pos_reply(rd_ix, wr_ix, mark_ix));
            default:
            begin
            end
        endcase
    endtask

    // Offers one item, starting at a falling edge, and returns at the falling edge after it
    // was taken. A fixed result replaces whatever the predictor queued for the item.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] data,
                            input logic [LEN_W-1:0] len, input bit fixed,
                            input ring_result_t fixed_res);
        int queued;
        while (!no_idle && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len, data};
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queued = awaited_out.size();
        ring_apply(cmd, data, len);
        if (fixed)
        begin
            while (awaited_out.size() > queued)
                void'(awaited_out.pop_back());
            awaited_out.push_back(fixed_res);
        end
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (awaited_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_regs(input logic [LEVEL_W-1:0] level, input logic [BYTE_W-1:0] sep);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ALMOST_FULL;
        cfg_data  <= level;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        af_level = level;
        @(negedge clk);
        cfg_index <= CFG_SEPARATOR;
        cfg_data  <= {1'b0, sep};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sep_val = sep;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_burst(input int count);
        int done_n;
        int pick;
        logic [CMD_W-1:0] cmd;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0] len;
        done_n = 0;
        while (done_n < count)
        begin
            pick = $urandom_range(0, 99);
            data = BYTE_W'($urandom_range(0, 255));
            len  = LEN_W'($urandom_range(0, 127));
            if (pick < 55)
            begin
                cmd = CMD_PUSH;
                if ($urandom_range(0, 7) == 0)
                    data = sep_val;
            end
            else if (pick < 67)
            begin
                cmd = CMD_READ_COUNT;
                if ($urandom_range(0, 3) != 0)
                    len = LEN_W'($urandom_range(1, 8));
            end
            else if (pick < 82)
                cmd = CMD_READ_LINE;
            else if (pick < 90)
                cmd = CMD_QUERY;
            else if (pick < 94)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            send_cmd(cmd, data, len, 1'b0, NO_DATA);
            if (pick < 94)
                done_n++;
        end
    endtask

    // Receiver side: random back-pressure, or a long hold-off when the sender asks for one.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            m_tready <= rst_n && (no_idle || $urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_out.size() == 0)
            begin
                $error("unexpected result: tdata %h tuser %h tlast %b", m_tdata, m_tuser,
                       m_tlast);
                mismatch_count++;
            end
            else
            begin
                head_res = awaited_out.pop_front();
                if (m_tdata[7:0] !== head_res.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", head_res.out_byte, m_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_tlast !== head_res.last)
                begin
                    $error("last: expected %0b, got %0b", head_res.last, m_tlast);
                    mismatch_count++;
                end
                if (m_tuser[0] !== head_res.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", head_res.empty_res, m_tuser[0]);
                    mismatch_count++;
                end
                if (m_tdata[16:8] !== head_res.read_pos)
                begin
                    $error("read_pos: expected %0d, got %0d", head_res.read_pos, m_tdata[16:8]);
                    mismatch_count++;
                end
                if (m_tdata[25:17] !== head_res.write_pos)
                begin
                    $error("write_pos: expected %0d, got %0d", head_res.write_pos,
                           m_tdata[25:17]);
                    mismatch_count++;
                end
                if (m_tdata[34:26] !== head_res.mark_pos)
                begin
                    $error("mark_pos: expected %0d, got %0d", head_res.mark_pos, m_tdata[34:26]);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int r;
        int k;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        wr_ix = '0;
        rd_ix = '0;
        mark_ix = '0;
        af_level = LEVEL_RESET;
        sep_val = SEP_RESET;

        directed_rows = '{
            '{CMD_QUERY,      8'h00, 7'd0,   1,  1'b1, pos_reply(9'd0, 9'd0, 9'd0)},
            '{CMD_READ_COUNT, 8'h00, 7'd0,   1,  1'b1, NO_DATA},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b1, NO_DATA},
            '{CMD_READ_COUNT, 8'h00, 7'd1,   1,  1'b1, NO_DATA},
            '{CMD_PUSH,       8'h00, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_PUSH,       8'hFF, 7'd127, 1,  1'b0, NO_DATA},
            '{CMD_PUSH,       8'h55, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_PUSH,       8'h0A, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_PUSH,       8'hAA, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_QUERY,      8'h00, 7'd0,   1,  1'b1, pos_reply(9'd0, 9'd5, 9'd4)},
            '{CMD_RSVD_LO,    8'hFF, 7'd127, 1,  1'b0, NO_DATA},
            '{CMD_RSVD_HI,    8'h0A, 7'd1,   1,  1'b0, NO_DATA},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b1, NO_DATA},
            '{CMD_READ_COUNT, 8'h00, 7'd127, 1,  1'b1, NO_DATA},
            '{CMD_READ_COUNT, 8'h00, 7'd1,   1,  1'b0, NO_DATA},
            '{CMD_CLEAR,      8'hFF, 7'd127, 1,  1'b0, NO_DATA},
            '{CMD_QUERY,      8'h00, 7'd0,   1,  1'b1, pos_reply(9'd5, 9'd5, 9'd5)},
            '{CMD_PUSH,       8'h20, 7'd0,   70, 1'b0, NO_DATA},
            '{CMD_PUSH,       8'h0A, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b0, NO_DATA},
            '{CMD_PUSH,       8'hC3, 7'd0,   64, 1'b0, NO_DATA},
            '{CMD_READ_COUNT, 8'h00, 7'd64,  1,  1'b0, NO_DATA},
            '{CMD_READ_COUNT, 8'h00, 7'd64,  1,  1'b1, NO_DATA},
            '{CMD_QUERY,      8'h00, 7'd0,   1,  1'b1, pos_reply(9'd140, 9'd140, 9'd76)},
            '{CMD_READ_LINE,  8'h00, 7'd0,   1,  1'b1, NO_DATA}
        };

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The directed table runs with no idling on either side.
        no_idle = 1'b1;
        for (r = 0; r < NUM_ROWS; r++)
            for (k = 0; k < directed_rows[r].reps; k++)
                send_cmd(directed_rows[r].cmd, directed_rows[r].data + BYTE_W'(k),
                         directed_rows[r].len, directed_rows[r].fixed, directed_rows[r].res);
        drain();
        no_idle = 1'b0;

        set_regs(9'd0, 8'h00);
        random_burst(5);
        drain();

        // Reads pile up behind a long receiver hold-off until the input stalls.
        set_regs(9'd60, 8'h3A);
        repeat (6)
            send_cmd(CMD_PUSH, BYTE_W'($urandom_range(0, 255)), 7'd0, 1'b0, NO_DATA);
        hold_req = 1'b1;
        repeat (3)
        begin
            send_cmd(CMD_READ_COUNT, 8'h00, 7'd2, 1'b0, NO_DATA);
            send_cmd(CMD_QUERY, 8'h00, 7'd0, 1'b0, NO_DATA);
        end
        drain();

        set_regs(LEVEL_W'($urandom_range(1, 510)), BYTE_W'($urandom_range(0, 255)));
        random_burst(5);
        drain();

        set_regs(LEVEL_RESET, SEP_RESET);
        random_burst(5);
        drain();

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* uart_rx_line_ring_buffer_unit.f */
rtl/rxlb_pkg.sv
rtl/rxlb_front.sv
rtl/rxlb_back.sv
rtl/uart_rx_line_ring_buffer_unit.sv
rtl/rxlb_checker.sv
tb/uart_rx_line_ring_buffer_unit_test.sv
